>>> src/cti_pkg.sv
// Shared constants, codes, types and state encoding for the curve table interpolator.
`default_nettype none
package cti_pkg;
	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = ADDR_W + 1;
	localparam int MAX_SAMPLES = 64;
	localparam int CFG_W = 7;
	localparam logic [CFG_W-1:0] CFG_RESET = 7'd25;
	localparam int TOTAL_W = 12;
	localparam int DATA_W = 32;
	localparam int WGT_W = $clog2(MAX_SAMPLES * MAX_SAMPLES * MAX_SAMPLES + 1);
	localparam int MUL_W = DATA_W + 1;
	localparam int ACC_W = 64;
	localparam int DIV_N_W = 64;
	localparam int DIV_D_W = DATA_W + 1;
	localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

	localparam logic [1:0] OP_LINEAR = 2'd0;
	localparam logic [1:0] OP_BEZIER = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_BAD_COUNT = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;
	localparam logic [1:0] STAT_OVERFLOW = 2'd3;

	typedef enum logic [4:0] {
		S_IDLE,
		S_POINT,
		S_FIN,
		S_REPLY,
		S_Q_RD0,
		S_Q_CHK0,
		S_Q_CHKN,
		S_Q_SRCH,
		S_Q_CMP,
		S_Q_MUL,
		S_Q_PROD,
		S_Q_DIV,
		S_B_WGT1,
		S_B_WGT2,
		S_B_MUL,
		S_B_ACC,
		S_B_DSTART,
		S_B_DIV,
		S_B_KEEP
	} seq_state_t;

	typedef struct packed {
		logic start;
		logic [DIV_N_W-1:0] dividend;
		logic [DIV_D_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DIV_N_W-1:0] quotient;
	} div_rsp_t;
endpackage
`default_nettype wire

>>> src/cti_in_if.sv
// Input channel: valid/ready handshake carrying one load point or query per beat.
`default_nettype none
interface cti_in_if import cti_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] opcode;
	logic first_of_load;
	logic [TOTAL_W-1:0] total_points;
	logic signed [DATA_W-1:0] point_x;
	logic signed [DATA_W-1:0] point_y;
	logic signed [DATA_W-1:0] query_x;

	modport source (output valid, opcode, first_of_load, total_points, point_x, point_y,
		query_x, input ready);
	modport sink (input valid, opcode, first_of_load, total_points, point_x, point_y,
		query_x, output ready);
endinterface
`default_nettype wire

>>> src/cti_out_if.sv
// Output channel: valid/ready handshake carrying one reply per beat.
`default_nettype none
interface cti_out_if import cti_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [DATA_W-1:0] result_y;
	logic [1:0] status;
	logic [CNT_W-1:0] stored_count;
	logic is_load_reply;

	modport source (output valid, result_y, status, stored_count, is_load_reply, input ready);
	modport sink (input valid, result_y, status, stored_count, is_load_reply, output ready);
endinterface
`default_nettype wire

>>> src/cti_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module cti_divider import cti_pkg::*; (
	input wire clk,
	input wire arst_n,
	input var div_req_t req,
	output var div_rsp_t rsp
);
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] dvs_q;
	logic [DIV_N_W-1:0] quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic done_q;
	logic [DIV_D_W:0] trial;
	logic [DIV_D_W:0] diff;
	logic fits;

	assign trial = {rem_q, quo_q[DIV_N_W-1]};
	assign fits = trial >= {1'b0, dvs_q};
	assign diff = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= DIV_CNT_W'(DIV_N_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
			quo_q <= {quo_q[DIV_N_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
endmodule
`default_nettype wire

>>> src/curve_table_interpolator.sv
// Curve table interpolator: loads a piecewise linear curve, from linear points or Bezier
// segments, and answers lookups.
// Channels: in_ch takes one beat per load point or query, out_ch gives one
// reply beat per query and one per finished or rejected load. cfg_we/cfg_wdata
// write the Bezier samples per segment S; write it only while the block is idle.
// in_ch.ready is high only while the sequencer is idle: one item at a time.
// Steps, using the shared divider and the single multiplier:
//   linear point: stored, then counted down; the last point of a load offers the reply;
//   Bezier point that closes a segment: for each of the S samples the weights,
//   the weighted sum and a divide for x, then for y, then the sample is kept;
//   query: read the first and last entries, L halving steps of the search
//   (ceil(log2(N - 1)) for an N point table), a multiply, then a divide; the
//   query goes straight to the reply when the table is empty, after the first entry
//   when clamped below the table, after the last when clamped above or one point is held.
// A rejected load count goes straight to its reply.
// Reset clears the table count, load state and output; S returns to 25.
// The table memory itself is not cleared: only entries below the count are read.
// A stalled receiver holds the reply in the output register; the block still
// works on the next item and waits only when a second reply is ready.
`default_nettype none
module curve_table_interpolator import cti_pkg::*; (
	input wire clk,
	input wire arst_n,
	input wire cfg_we,
	input wire [CFG_W-1:0] cfg_wdata,
	cti_in_if.sink in_ch,
	cti_out_if.source out_ch
);
	seq_state_t state_q, state_d;

	logic [CFG_W-1:0] cfg_q;
	logic [CFG_W-1:0] s_eff;
	logic [CNT_W-1:0] count_q;
	logic [TOTAL_W-1:0] remaining_q;
	logic rejected_q;
	logic bez_q;
	logic [1:0] fill_q;
	logic ovf_q;
	logic signed [DATA_W-1:0] last_x_q;

	logic signed [DATA_W-1:0] px_q, py_q, qx_q;
	logic signed [DATA_W-1:0] win_x_q [3];
	logic signed [DATA_W-1:0] win_y_q [3];

	logic [2*DATA_W-1:0] mem [TABLE_DEPTH];
	logic [2*DATA_W-1:0] rd_q;
	logic [ADDR_W-1:0] rd_addr;
	logic wr_en;
	logic signed [DATA_W-1:0] rdx, rdy;

	logic [ADDR_W-1:0] lo_q, hi_q, mid_q, mid;
	logic signed [DATA_W-1:0] lo_x_q, lo_y_q, hi_x_q, hi_y_q;
	logic neg_q;
	logic [CNT_W-1:0] last_idx;
	logic signed [DATA_W:0] dx, dy, qa, mag;

	logic [CFG_W-1:0] i_q, r;
	logic [2*CFG_W-1:0] rr_q, ii_q, ir_q;
	logic [3*CFG_W-1:0] t0, t1, t2, t3;
	logic [3*CFG_W+1:0] t1x3, t2x3;
	logic [WGT_W-1:0] w_q [4];
	logic [WGT_W-1:0] d_q;
	logic [1:0] k_q;
	logic c_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] bn, bden;
	logic signed [DATA_W-1:0] bx_q, by_q;
	logic signed [DATA_W-1:0] qv;

	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [2*MUL_W-1:0] prod_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic keep_en, keep_skip, keep_full;
	logic signed [DATA_W-1:0] keep_x, keep_y;

	logic in_acc;
	logic in_bez, in_bad, in_stray;

	logic signed [DATA_W-1:0] rep_y_q;
	logic [1:0] rep_stat_q;
	logic rep_load_q;
	logic out_valid_q;
	logic signed [DATA_W-1:0] out_y_q;
	logic [1:0] out_stat_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic out_load_q;
	logic out_free;

	function automatic logic mult_of_3(input logic [TOTAL_W-1:0] v);
		logic [4:0] s1;
		logic [2:0] s2;
		logic [2:0] s3;
		s1 = '0;
		for (int j = 0; j < TOTAL_W / 2; j++) begin
			s1 = s1 + 5'(v[2*j +: 2]);
		end
		s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
		s3 = 3'(s2[1:0]) + 3'(s2[2]);
		return (s3 == 3'd0) || (s3 == 3'd3);
	endfunction

	cti_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	assign s_eff = (cfg_q == '0) ? CFG_W'(1) :
		(cfg_q > CFG_W'(MAX_SAMPLES)) ? CFG_W'(MAX_SAMPLES) : cfg_q;

	assign in_acc = in_ch.valid && in_ch.ready;
	assign in_bez = in_ch.opcode == OP_BEZIER;
	assign in_bad = in_bez ?
		((in_ch.total_points < TOTAL_W'(4)) ||
		!mult_of_3(in_ch.total_points - TOTAL_W'(4))) :
		(in_ch.total_points == '0);
	assign in_stray = (remaining_q == '0) || rejected_q || (bez_q != in_bez);

	assign rdx = rd_q[DATA_W-1:0];
	assign rdy = rd_q[2*DATA_W-1:DATA_W];
	assign last_idx = count_q - 1'b1;
	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign dx = {hi_x_q[DATA_W-1], hi_x_q} - {lo_x_q[DATA_W-1], lo_x_q};
	assign dy = {hi_y_q[DATA_W-1], hi_y_q} - {lo_y_q[DATA_W-1], lo_y_q};
	assign qa = {qx_q[DATA_W-1], qx_q} - {lo_x_q[DATA_W-1], lo_x_q};
	assign mag = dy[DATA_W] ? -dy : dy;

	assign r = s_eff - i_q;
	assign t0 = rr_q * r;
	assign t1 = ir_q * r;
	assign t2 = ir_q * i_q;
	assign t3 = ii_q * i_q;
	assign t1x3 = {2'b00, t1} + {1'b0, t1, 1'b0};
	assign t2x3 = {2'b00, t2} + {1'b0, t2, 1'b0};

	assign bn = (acc_q <<< 1) + ACC_W'(d_q);
	assign bden = ACC_W'({d_q, 1'b0});
	assign qv = neg_q ? -div_rsp.quotient[DATA_W-1:0] : div_rsp.quotient[DATA_W-1:0];

	assign keep_skip = (count_q != '0) && (keep_x <= last_x_q);
	assign keep_full = count_q >= CNT_W'(TABLE_DEPTH);
	assign wr_en = keep_en && !keep_skip && !keep_full;
	assign out_free = !out_valid_q || out_ch.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (in_ch.opcode)
						OP_QUERY: state_d = (count_q == '0) ? S_REPLY : S_Q_RD0;
						OP_LINEAR, OP_BEZIER: begin
							if (in_ch.first_of_load) begin
								state_d = in_bad ? S_REPLY : S_POINT;
							end else if (!in_stray) begin
								state_d = S_POINT;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_POINT: begin
				if (bez_q && fill_q == 2'd3) begin
					state_d = S_B_WGT1;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: state_d = (remaining_q == TOTAL_W'(1)) ? S_REPLY : S_IDLE;
			S_REPLY: state_d = out_free ? S_IDLE : S_REPLY;
			S_Q_RD0: state_d = S_Q_CHK0;
			S_Q_CHK0: state_d = (qx_q < rdx) ? S_REPLY : S_Q_CHKN;
			S_Q_CHKN: begin
				state_d = ((qx_q > rdx) || (count_q == CNT_W'(1))) ? S_REPLY : S_Q_SRCH;
			end
			S_Q_SRCH: state_d = ((hi_q - lo_q) > ADDR_W'(1)) ? S_Q_CMP : S_Q_MUL;
			S_Q_CMP: state_d = S_Q_SRCH;
			S_Q_MUL: state_d = S_Q_PROD;
			S_Q_PROD: state_d = S_Q_DIV;
			S_Q_DIV: state_d = div_rsp.done ? S_REPLY : S_Q_DIV;
			S_B_WGT1: state_d = S_B_WGT2;
			S_B_WGT2: state_d = S_B_MUL;
			S_B_MUL: state_d = S_B_ACC;
			S_B_ACC: state_d = (k_q == 2'd3) ? S_B_DSTART : S_B_MUL;
			S_B_DSTART: state_d = S_B_DIV;
			S_B_DIV: begin
				if (div_rsp.done) begin
					state_d = c_q ? S_B_KEEP : S_B_MUL;
				end
			end
			S_B_KEEP: state_d = (i_q == s_eff - 1'b1) ? S_FIN : S_B_WGT1;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = state_q == S_IDLE;
		rd_addr = '0;
		mul_a = '0;
		mul_b = '0;
		div_req = '0;
		keep_en = 1'b0;
		keep_x = px_q;
		keep_y = py_q;
		case (state_q)
			S_POINT: keep_en = !bez_q;
			S_Q_CHK0: rd_addr = last_idx[ADDR_W-1:0];
			S_Q_SRCH: rd_addr = mid;
			S_Q_MUL: begin
				mul_a = {1'b0, qa[DATA_W-1:0]};
				mul_b = {1'b0, mag[DATA_W-1:0]};
			end
			S_Q_PROD: begin
				div_req.start = 1'b1;
				div_req.dividend = prod_q[DIV_N_W-1:0] + DIV_N_W'(dx[DATA_W:1]);
				div_req.divisor = dx[DIV_D_W-1:0];
			end
			S_B_MUL: begin
				mul_a = MUL_W'({1'b0, w_q[k_q]});
				if (c_q) begin
					mul_b = (k_q == 2'd3) ? MUL_W'(py_q) : MUL_W'(win_y_q[k_q]);
				end else begin
					mul_b = (k_q == 2'd3) ? MUL_W'(px_q) : MUL_W'(win_x_q[k_q]);
				end
			end
			S_B_DSTART: begin
				div_req.start = 1'b1;
				div_req.dividend = bn[ACC_W-1] ? (bden - bn - ACC_W'(1)) : bn;
				div_req.divisor = DIV_D_W'(bden);
			end
			S_B_KEEP: begin
				keep_en = 1'b1;
				keep_x = bx_q;
				keep_y = by_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cfg_q <= CFG_RESET;
			count_q <= '0;
			remaining_q <= '0;
			rejected_q <= 1'b0;
			bez_q <= 1'b0;
			fill_q <= '0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
			i_q <= '0;
			k_q <= '0;
			c_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (state_q == S_IDLE && in_acc && in_ch.first_of_load &&
				(in_ch.opcode == OP_LINEAR || in_ch.opcode == OP_BEZIER)) begin
				fill_q <= '0;
				if (in_bad) begin
					rejected_q <= 1'b1;
					remaining_q <= '0;
				end else begin
					rejected_q <= 1'b0;
					bez_q <= in_bez;
					count_q <= '0;
					ovf_q <= 1'b0;
					remaining_q <= in_ch.total_points;
				end
			end
			if (keep_en && !keep_skip) begin
				if (keep_full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
			case (state_q)
				S_POINT: begin
					if (bez_q && fill_q != 2'd3) begin
						fill_q <= fill_q + 1'b1;
					end
					i_q <= '0;
				end
				S_FIN: remaining_q <= remaining_q - 1'b1;
				S_B_WGT2: begin
					k_q <= '0;
					c_q <= 1'b0;
				end
				S_B_ACC: k_q <= k_q + 1'b1;
				S_B_DIV: begin
					if (div_rsp.done && !c_q) begin
						c_q <= 1'b1;
						k_q <= '0;
					end
				end
				S_B_KEEP: begin
					if (i_q == s_eff - 1'b1) begin
						fill_q <= 2'd1;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (state_q == S_REPLY && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[ADDR_W-1:0]] <= {keep_y, keep_x};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (wr_en) begin
			last_x_q <= keep_x;
		end
		if (state_q == S_REPLY && out_free) begin
			out_y_q <= rep_y_q;
			out_stat_q <= rep_stat_q;
			out_cnt_q <= count_q;
			out_load_q <= rep_load_q;
		end
		case (state_q)
			S_IDLE: begin
				px_q <= in_ch.point_x;
				py_q <= in_ch.point_y;
				qx_q <= in_ch.query_x;
				rep_y_q <= '0;
				rep_load_q <= in_ch.opcode != OP_QUERY;
				rep_stat_q <= (in_ch.opcode == OP_QUERY) ? STAT_EMPTY : STAT_BAD_COUNT;
			end
			S_POINT: begin
				if (bez_q && fill_q != 2'd3) begin
					win_x_q[fill_q] <= px_q;
					win_y_q[fill_q] <= py_q;
				end
			end
			S_FIN: begin
				rep_y_q <= '0;
				rep_load_q <= 1'b1;
				rep_stat_q <= ovf_q ? STAT_OVERFLOW : STAT_OK;
			end
			S_Q_CHK0: begin
				lo_q <= '0;
				lo_x_q <= rdx;
				lo_y_q <= rdy;
				rep_y_q <= rdy;
				rep_stat_q <= STAT_OK;
				rep_load_q <= 1'b0;
			end
			S_Q_CHKN: begin
				hi_q <= last_idx[ADDR_W-1:0];
				hi_x_q <= rdx;
				hi_y_q <= rdy;
				rep_y_q <= (qx_q > rdx) ? rdy : lo_y_q;
			end
			S_Q_SRCH: mid_q <= mid;
			S_Q_CMP: begin
				if (rdx > qx_q) begin
					hi_q <= mid_q;
					hi_x_q <= rdx;
					hi_y_q <= rdy;
				end else begin
					lo_q <= mid_q;
					lo_x_q <= rdx;
					lo_y_q <= rdy;
				end
			end
			S_Q_MUL: neg_q <= dy[DATA_W];
			S_Q_DIV: begin
				rep_y_q <= neg_q ? lo_y_q - div_rsp.quotient[DATA_W-1:0] :
					lo_y_q + div_rsp.quotient[DATA_W-1:0];
			end
			S_B_WGT1: begin
				rr_q <= r * r;
				ii_q <= i_q * i_q;
				ir_q <= i_q * r;
			end
			S_B_WGT2: begin
				w_q[0] <= WGT_W'(t0);
				w_q[1] <= WGT_W'(t1x3);
				w_q[2] <= WGT_W'(t2x3);
				w_q[3] <= WGT_W'(t3);
				if (i_q == '0) begin
					d_q <= WGT_W'(t0);
				end
				acc_q <= '0;
			end
			S_B_ACC: acc_q <= acc_q + prod_q[ACC_W-1:0];
			S_B_DSTART: neg_q <= bn[ACC_W-1];
			S_B_DIV: begin
				if (div_rsp.done) begin
					acc_q <= '0;
					if (c_q) begin
						by_q <= qv;
					end else begin
						bx_q <= qv;
					end
				end
			end
			S_B_KEEP: begin
				if (i_q == s_eff - 1'b1) begin
					win_x_q[0] <= px_q;
					win_y_q[0] <= py_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.result_y = out_y_q;
	assign out_ch.status = out_stat_q;
	assign out_ch.stored_count = out_cnt_q;
	assign out_ch.is_load_reply = out_load_q;
endmodule
`default_nettype wire

>>> src/cti_checker.sv
// Port-level checks on the curve table interpolator, bound to the top level.
`default_nettype none
module cti_checker import cti_pkg::*; (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire in_ready,
	input wire [1:0] in_opcode,
	input wire out_valid,
	input wire out_ready,
	input wire [DATA_W-1:0] result_y,
	input wire [1:0] status,
	input wire [CNT_W-1:0] stored_count,
	input wire is_load_reply
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_y) && $stable(status))
		else $error("reply beat changed while stalled");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_opcode == OP_QUERY |=> !in_ready)
		else $error("query accepted without entering the lookup");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> stored_count <= CNT_W'(TABLE_DEPTH))
		else $error("stored count beyond table depth");

	a_empty_reply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_EMPTY |->
		result_y == '0 && !is_load_reply && stored_count == '0)
		else $error("empty-table reply malformed");

	a_bad_is_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_BAD_COUNT |-> is_load_reply && result_y == '0)
		else $error("bad count reply not marked as load reply");
endmodule

bind curve_table_interpolator cti_checker u_cti_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.in_opcode(in_ch.opcode),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.result_y(out_ch.result_y),
	.status(out_ch.status),
	.stored_count(out_ch.stored_count),
	.is_load_reply(out_ch.is_load_reply)
);
`default_nettype wire

>>> tb/curve_table_interpolator_test.sv
// Curve table interpolator testbench: directed and random loads and lookups checked against a local predictor.
`timescale 1ns / 100ps
`default_nettype none
module curve_table_interpolator_test;
	import cti_pkg::*;

	localparam int SETTLE_CYCLES = MAX_SAMPLES * 160 + 200;
	localparam int IDLE_LIMIT = 60000;

	typedef struct {
		logic [1:0] opcode;
		bit first_of_load;
		bit [TOTAL_W-1:0] total_points;
		bit signed [DATA_W-1:0] point_x;
		bit signed [DATA_W-1:0] point_y;
		bit signed [DATA_W-1:0] query_x;
	} beat_t;

	typedef struct {
		bit signed [DATA_W-1:0] result_y;
		logic [1:0] status;
		bit [CNT_W-1:0] stored_count;
		bit is_load_reply;
	} reply_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	cti_in_if in_ch();
	cti_out_if out_ch();

	curve_table_interpolator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	beat_t pending_beats[$];
	reply_t expected_replies[$];
	int sent_beats;
	int taken_beats;
	int mismatches;
	int idle_cycles;

	// predictor state
	longint curve_x[TABLE_DEPTH];
	longint curve_y[TABLE_DEPTH];
	int curve_count;
	int load_left;
	bit load_dead;
	longint ctrl_x[3];
	longint ctrl_y[3];
	int ctrl_fill;
	bit dropped_point;
	bit bezier_kind;
	int samples_cfg;

	// generator hints
	longint hint_lo;
	longint hint_hi;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint floor_quot(longint n, longint d);
		longint q;
		q = n / d;
		if (n % d < 0)
			q--;
		return q;
	endfunction

	function automatic void keep_curve_point(longint x, longint y);
		if (curve_count > 0 && x <= curve_x[curve_count - 1])
			return;
		if (curve_count >= TABLE_DEPTH) begin
			dropped_point = 1'b1;
			return;
		end
		curve_x[curve_count] = x;
		curve_y[curve_count] = y;
		curve_count++;
	endfunction

	function automatic void sample_bezier(longint x3, longint y3);
		longint s, d, r, w0, w1, w2, w3, nx, ny;
		s = samples_cfg;
		if (s < 1)
			s = 1;
		if (s > MAX_SAMPLES)
			s = MAX_SAMPLES;
		d = s * s * s;
		for (longint i = 0; i < s; i++) begin
			r = s - i;
			w0 = r * r * r;
			w1 = 3 * i * r * r;
			w2 = 3 * i * i * r;
			w3 = i * i * i;
			nx = w0 * ctrl_x[0] + w1 * ctrl_x[1] + w2 * ctrl_x[2] + w3 * x3;
			ny = w0 * ctrl_y[0] + w1 * ctrl_y[1] + w2 * ctrl_y[2] + w3 * y3;
			keep_curve_point(floor_quot(2 * nx + d, 2 * d), floor_quot(2 * ny + d, 2 * d));
		end
	endfunction

	function automatic longint interpolate(longint x);
		int unsigned lo, hi, mid;
		bit [63:0] a, dx, mag, q;
		longint dy;
		lo = 0;
		hi = curve_count - 1;
		if (x < curve_x[0])
			return curve_y[0];
		if (x > curve_x[hi])
			return curve_y[hi];
		if (hi == 0)
			return curve_y[0];
		while (hi - lo > 1) begin
			mid = lo + (hi - lo) / 2;
			if (curve_x[mid] > x)
				hi = mid;
			else
				lo = mid;
		end
		a = x - curve_x[lo];
		dx = curve_x[hi] - curve_x[lo];
		dy = curve_y[hi] - curve_y[lo];
		mag = dy < 0 ? -dy : dy;
		q = (a * mag + dx / 2) / dx;
		return dy < 0 ? curve_y[lo] - longint'(q) : curve_y[lo] + longint'(q);
	endfunction

	function automatic void post_reply(longint y, logic [1:0] st, bit is_load);
		reply_t r;
		r.result_y = y[31:0];
		r.status = st;
		r.stored_count = curve_count;
		r.is_load_reply = is_load;
		expected_replies.push_back(r);
	endfunction

	function automatic void predict_beat(beat_t b);
		bit bez, bad;
		if (b.opcode == OP_QUERY) begin
			if (curve_count == 0)
				post_reply(0, STAT_EMPTY, 1'b0);
			else
				post_reply(interpolate(b.query_x), STAT_OK, 1'b0);
			return;
		end
		if (b.opcode != OP_LINEAR && b.opcode != OP_BEZIER)
			return;
		if (b.first_of_load) begin
			bez = (b.opcode == OP_BEZIER);
			bad = bez ? (b.total_points < 4 || (b.total_points - 4) % 3 != 0)
				: (b.total_points == 0);
			ctrl_fill = 0;
			if (bad) begin
				load_dead = 1'b1;
				load_left = 0;
				post_reply(0, STAT_BAD_COUNT, 1'b1);
				return;
			end
			load_dead = 1'b0;
			bezier_kind = bez;
			curve_count = 0;
			dropped_point = 1'b0;
			load_left = b.total_points;
		end else if (load_left == 0 || load_dead || bezier_kind != (b.opcode == OP_BEZIER)) begin
			return;
		end
		if (!bezier_kind) begin
			keep_curve_point(b.point_x, b.point_y);
		end else if (ctrl_fill < 3) begin
			ctrl_x[ctrl_fill] = b.point_x;
			ctrl_y[ctrl_fill] = b.point_y;
			ctrl_fill++;
		end else begin
			sample_bezier(b.point_x, b.point_y);
			ctrl_x[0] = b.point_x;
			ctrl_y[0] = b.point_y;
			ctrl_fill = 1;
		end
		load_left--;
		if (load_left == 0)
			post_reply(0, dropped_point ? STAT_OVERFLOW : STAT_OK, 1'b1);
	endfunction

	function automatic void add_beat(logic [1:0] op, bit first, int total, int px, int py,
			int qx);
		beat_t b;
		b.opcode = op;
		b.first_of_load = first;
		b.total_points = total;
		b.point_x = px;
		b.point_y = py;
		b.query_x = qx;
		pending_beats.push_back(b);
	endfunction

	function automatic int pick_query_x();
		int k;
		longint span;
		k = $urandom_range(0, 9);
		span = hint_hi - hint_lo;
		if (k == 0)
			return $urandom;
		if (k == 1)
			return hint_lo - $urandom_range(0, 1000);
		if (k == 2)
			return hint_hi + $urandom_range(0, 1000);
		if (k == 3)
			return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
		if (k == 4)
			return hint_lo;
		if (span <= 0)
			return hint_lo;
		return hint_lo + longint'({$urandom, $urandom} % span);
	endfunction

	function automatic void gen_linear_load(int n);
		longint x, step;
		int y;
		x = $signed($urandom) >>> $urandom_range(0, 8);
		hint_lo = x;
		for (int i = 0; i < n; i++) begin
			y = $urandom;
			if ($urandom_range(0, 99) < 12) begin
				add_beat(OP_LINEAR, i == 0, n, $urandom, y, $urandom);
			end else begin
				step = $urandom_range(1, 1 << $urandom_range(0, 24));
				if (i > 0 && x + step <= 64'sd2147483647)
					x = x + step;
				add_beat(OP_LINEAR, i == 0, n, x, y, $urandom);
			end
		end
		hint_hi = x;
	endfunction

	function automatic void gen_bezier_load(int segs);
		longint x;
		int n;
		n = 4 + 3 * segs;
		x = -($urandom_range(0, 1 << 28));
		hint_lo = x;
		for (int i = 0; i < n; i++) begin
			if (i > 0)
				x = x + $urandom_range(1, 1 << $urandom_range(4, 24));
			if ($urandom_range(0, 99) < 10 && i > 0)
				add_beat(OP_BEZIER, 1'b0, $urandom, x - $urandom_range(0, 1 << 20), $urandom,
					$urandom);
			else
				add_beat(OP_BEZIER, i == 0, n, x, $urandom, $urandom);
		end
		hint_hi = x;
	endfunction

	function automatic void gen_mixed(int actions, int seg_budget);
		int k, segs, t;
		for (int a = 0; a < actions; a++) begin
			k = $urandom_range(0, 99);
			if (k < 28) begin
				gen_linear_load($urandom_range(1, 14));
			end else if (k < 42 && seg_budget > 0) begin
				segs = $urandom_range(0, (seg_budget < 3) ? seg_budget : 3);
				seg_budget -= (segs == 0) ? 1 : segs;
				gen_bezier_load(segs);
			end else if (k < 78) begin
				repeat ($urandom_range(1, 4))
					add_beat(OP_QUERY, $urandom_range(0, 1), $urandom, $urandom, $urandom,
						pick_query_x());
			end else if (k < 85) begin
				if ($urandom_range(0, 1)) begin
					add_beat(OP_LINEAR, 1'b1, 0, $urandom, $urandom, $urandom);
				end else begin
					do t = $urandom_range(0, 4095); while (t >= 4 && (t - 4) % 3 == 0);
					add_beat(OP_BEZIER, 1'b1, t, $urandom, $urandom, $urandom);
				end
			end else if (k < 91) begin
				add_beat($urandom_range(0, 1), 1'b0, $urandom, $urandom, $urandom, $urandom);
			end else if (k < 95) begin
				add_beat(2'd3, $urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom);
			end else begin
				// open a long load and leave it unfinished
				add_beat($urandom_range(0, 1) ? OP_BEZIER : OP_LINEAR, 1'b1, 4093, $urandom,
					$urandom, $urandom);
			end
		end
	endfunction

	task automatic write_samples(logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		samples_cfg = v;
	endtask

	task automatic drain_and_settle();
		while (pending_beats.size() > 0 || expected_replies.size() > 0
				|| sent_beats != taken_beats)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// beat sender: bursts with random gaps
	int burst_left;
	int gap_left;
	always @(negedge clk) begin
		if (arst_n && !(in_ch.valid && sent_beats != taken_beats)) begin
			if (gap_left > 0) begin
				in_ch.valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_beats.size() > 0) begin
				beat_t b;
				b = pending_beats.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.opcode <= b.opcode;
				in_ch.first_of_load <= b.first_of_load;
				in_ch.total_points <= b.total_points;
				in_ch.point_x <= b.point_x;
				in_ch.point_y <= b.point_y;
				in_ch.query_x <= b.query_x;
				sent_beats <= sent_beats + 1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 30);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// reply receiver stall pattern
	int stall_left;
	int cyc;
	always @(negedge clk) begin
		int r;
		cyc <= cyc + 1;
		r = $urandom_range(0, 99);
		if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (cyc[10:9] == 2'd0) begin
			out_ch.ready <= 1'b1;
		end else begin
			if (r < 3)
				stall_left <= $urandom_range(5, 40);
			out_ch.ready <= (r >= 25);
		end
	end

	always @(posedge clk) begin
		reply_t e;
		if (in_ch.valid && in_ch.ready) begin
			beat_t b;
			b.opcode = in_ch.opcode;
			b.first_of_load = in_ch.first_of_load;
			b.total_points = in_ch.total_points;
			b.point_x = in_ch.point_x;
			b.point_y = in_ch.point_y;
			b.query_x = in_ch.query_x;
			predict_beat(b);
			taken_beats <= taken_beats + 1;
		end
		if (out_ch.valid && out_ch.ready) begin
			if (expected_replies.size() == 0) begin
				$error("reply with nothing expected: result_y %0d status %0d", out_ch.result_y,
					out_ch.status);
				mismatches++;
			end else begin
				e = expected_replies.pop_front();
				if (out_ch.result_y !== e.result_y) begin
					$error("result_y expected %0d actual %0d", e.result_y, out_ch.result_y);
					mismatches++;
				end
				if (out_ch.status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, out_ch.status);
					mismatches++;
				end
				if (out_ch.stored_count !== e.stored_count) begin
					$error("stored_count expected %0d actual %0d", e.stored_count,
						out_ch.stored_count);
					mismatches++;
				end
				if (out_ch.is_load_reply !== e.is_load_reply) begin
					$error("is_load_reply expected %0d actual %0d", e.is_load_reply,
						out_ch.is_load_reply);
					mismatches++;
				end
			end
		end
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else if (pending_beats.size() > 0 || expected_replies.size() > 0 || in_ch.valid)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [CFG_W-1:0] settings[7];
		settings = '{7'd1, 7'd64, 7'd3, 7'd0, 7'd127, 7'd7, 7'd2};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.opcode = OP_QUERY;
		in_ch.first_of_load = 1'b0;
		in_ch.total_points = '0;
		in_ch.point_x = '0;
		in_ch.point_y = '0;
		in_ch.query_x = '0;
		out_ch.ready = 1'b0;
		sent_beats = 0;
		taken_beats = 0;
		mismatches = 0;
		idle_cycles = 0;
		burst_left = 1;
		gap_left = 0;
		stall_left = 0;
		cyc = 0;
		curve_count = 0;
		load_left = 0;
		load_dead = 1'b0;
		ctrl_fill = 0;
		dropped_point = 1'b0;
		bezier_kind = 1'b0;
		samples_cfg = CFG_RESET;
		hint_lo = 0;
		hint_hi = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, one point, extreme span, bezier, bad counts, strays
		add_beat(OP_QUERY, 1'b0, 0, 0, 0, 0);
		add_beat(OP_LINEAR, 1'b1, 1, 32'h80000000, 32'h7fffffff, 32'hffffffff);
		add_beat(OP_QUERY, 1'b1, 4095, 0, 0, 32'h80000000);
		add_beat(OP_QUERY, 1'b0, 0, 0, 0, 32'h7fffffff);
		add_beat(OP_LINEAR, 1'b1, 3, 32'h80000000, 32'h80000000, 0);
		add_beat(OP_LINEAR, 1'b0, 3, 0, 32'h7fffffff, 0);
		add_beat(OP_LINEAR, 1'b0, 3, 32'h7fffffff, 32'h80000000, 0);
		add_beat(OP_QUERY, 1'b0, 0, 0, 0, 32'hc0000001);
		add_beat(OP_QUERY, 1'b0, 0, 0, 0, 32'h3fffffff);
		add_beat(OP_QUERY, 1'b0, 0, 0, 0, 0);
		add_beat(OP_BEZIER, 1'b1, 4, -1000000, 5000, 0);
		add_beat(OP_BEZIER, 1'b0, 4, -200000, -900000, 0);
		add_beat(OP_LINEAR, 1'b0, 4, 7, 7, 0);
		add_beat(OP_BEZIER, 1'b0, 4, 300000, 900000, 0);
		add_beat(OP_BEZIER, 1'b0, 4, 1000000, -5000, 0);
		add_beat(OP_QUERY, 1'b0, 0, 0, 0, 123457);
		add_beat(OP_LINEAR, 1'b1, 0, 0, 0, 0);
		add_beat(OP_BEZIER, 1'b1, 5, 0, 0, 0);
		add_beat(OP_BEZIER, 1'b1, 3, 0, 0, 0);
		add_beat(OP_LINEAR, 1'b0, 2, 1, 1, 0);
		add_beat(2'd3, 1'b1, 4095, 32'hffffffff, 32'hffffffff, 32'hffffffff);
		add_beat(OP_QUERY, 1'b0, 0, 0, 0, 5);
		drain_and_settle();

		// fill past the table depth
		write_samples(settings[0]);
		gen_linear_load(TABLE_DEPTH + 30);
		gen_mixed(4, 10);
		drain_and_settle();

		for (int p = 1; p < 7; p++) begin
			int s;
			write_samples(settings[p]);
			s = (settings[p] == 0) ? 1 : (settings[p] > MAX_SAMPLES ? MAX_SAMPLES : settings[p]);
			gen_mixed(3, (s >= 32) ? 4 : 60 / s + 2);
			drain_and_settle();
		end
		write_samples($urandom_range(4, 12));
		gen_mixed(3, 10);
		drain_and_settle();

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire
